>>> sv/glfsr_pkg.sv
// Shared types, codes and the LFSR step function for the Galois LFSR range unit.
package glfsr_pkg;

   localparam int unsigned StateWidth  = 16;
   localparam int unsigned ValueWidth  = 17;
   localparam int unsigned CmdWidth    = 2;
   localparam int unsigned IterCount   = StateWidth;
   localparam int unsigned CountWidth  = $clog2(IterCount);

   localparam logic [CmdWidth-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CmdWidth-1:0] CMD_STEP  = 2'd1;
   localparam logic [CmdWidth-1:0] CMD_RANGE = 2'd2;

   // Feedback masks for the two shift directions.
   localparam logic [StateWidth-1:0] TapsRight = 16'hB400;
   localparam logic [StateWidth-1:0] TapsLeft  = 16'h002D;

   typedef struct packed {
      logic load_seed;
      logic step_raw;
      logic step_range;
      logic iterate;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic last_iter;
   } dp_status_type;

   // One step of the Galois LFSR in the selected direction.
   function automatic logic [StateWidth-1:0] lfsr_next(input logic [StateWidth-1:0] s,
                                                        input logic dir_left);
      logic [StateWidth-1:0] n;
      begin
         if (!dir_left) begin
            n = {1'b0, s[StateWidth-1:1]};
            if (s[0]) begin
               n = n ^ TapsRight;
            end
         end else begin
            n = {s[StateWidth-2:0], 1'b0};
            if (s[StateWidth-1]) begin
               n = n ^ TapsLeft;
            end
         end
         lfsr_next = n;
      end
   endfunction

endpackage

>>> sv/galois_lfsr16_random_range_unit.sv
// Top level of the 16-bit Galois LFSR random source with range reduction.
// A load gives no item; a raw step shows its item in the cycle after acceptance.
// A ranged step first steps the LFSR, then runs the bit-serial remainder unit.
// A ranged item holds the unit until its result is written and the output frees.
// Synchronous active-high reset clears the LFSR and the shift direction to zero
// and empties the output register.
module galois_lfsr16_random_range_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic                                 csr_shift_direction,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [glfsr_pkg::CmdWidth-1:0]       req_command,
   input  logic [glfsr_pkg::StateWidth-1:0]     req_seed,
   input  logic [glfsr_pkg::StateWidth-1:0]     req_range_low,
   input  logic [glfsr_pkg::StateWidth-1:0]     req_range_high,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [glfsr_pkg::ValueWidth-1:0]     rsp_value
);

   // Commands from the controller to the datapath, and the datapath's status back.
   glfsr_pkg::dp_cmd_type    dp_cmd;
   glfsr_pkg::dp_status_type dp_status;

   // The controller owns the handshakes and sequences the divide iterations.
   // Unused command codes are accepted and simply raise no datapath command.
   glfsr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status)
   );

   // The datapath holds the LFSR, the direction register and the remainder unit.
   // Reversed bounds load an all-ones divisor so the remainder equals the state.
   glfsr_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_shift_direction (csr_shift_direction),
      .req_seed            (req_seed),
      .req_range_low       (req_range_low),
      .req_range_high      (req_range_high),
      .rsp_value           (rsp_value),
      .dp_cmd              (dp_cmd),
      .dp_status           (dp_status)
   );

endmodule

>>> sv/glfsr_ctrl.sv
// Controller state machine: handshakes, divide sequencing and result valid.
module glfsr_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic [glfsr_pkg::CmdWidth-1:0]     req_command,
   output logic                               req_stall,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output glfsr_pkg::dp_cmd_type              dp_cmd,
   input  glfsr_pkg::dp_status_type           dp_status
);

   localparam logic [0:0] ST_IDLE   = 1'b0;
   localparam logic [0:0] ST_DIVIDE = 1'b1;

   logic [0:0] state_ff;
   logic [0:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       ready;
   logic       accept;

   // An item may enter only when idle and the output register is free or drains now.
   assign ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall);
   assign accept = req_valid && ready;

   assign req_stall = !ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      dp_cmd            = '0;
      dp_cmd.load_seed  = accept && (req_command == glfsr_pkg::CMD_LOAD);
      dp_cmd.step_raw   = accept && (req_command == glfsr_pkg::CMD_STEP);
      dp_cmd.step_range = accept && (req_command == glfsr_pkg::CMD_RANGE);
      dp_cmd.iterate    = (state_ff == ST_DIVIDE);
      dp_cmd.finish     = (state_ff == ST_DIVIDE) && dp_status.last_iter;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (dp_cmd.step_range) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (dp_status.last_iter) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.step_raw || dp_cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> sv/glfsr_datapath.sv
// Datapath: LFSR register, direction register, bit-serial remainder unit, output register.
module glfsr_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic                                 csr_shift_direction,
   input  logic [glfsr_pkg::StateWidth-1:0]     req_seed,
   input  logic [glfsr_pkg::StateWidth-1:0]     req_range_low,
   input  logic [glfsr_pkg::StateWidth-1:0]     req_range_high,
   output logic [glfsr_pkg::ValueWidth-1:0]     rsp_value,
   input  glfsr_pkg::dp_cmd_type                dp_cmd,
   output glfsr_pkg::dp_status_type             dp_status
);

   logic [glfsr_pkg::StateWidth-1:0] shift_ff;
   logic [glfsr_pkg::StateWidth-1:0] shift_in;
   logic                             dir_ff;
   logic [glfsr_pkg::StateWidth-1:0] next_state;

   logic [glfsr_pkg::ValueWidth-1:0] rem_ff;
   logic [glfsr_pkg::ValueWidth-1:0] rem_in;
   logic [glfsr_pkg::StateWidth-1:0] dvd_ff;
   logic [glfsr_pkg::StateWidth-1:0] dvd_in;
   logic [glfsr_pkg::ValueWidth-1:0] dsr_ff;
   logic [glfsr_pkg::ValueWidth-1:0] dsr_in;
   logic [glfsr_pkg::StateWidth-1:0] low_ff;
   logic [glfsr_pkg::StateWidth-1:0] low_in;
   logic [glfsr_pkg::CountWidth-1:0] count_ff;
   logic [glfsr_pkg::CountWidth-1:0] count_in;
   logic [glfsr_pkg::ValueWidth-1:0] value_ff;
   logic [glfsr_pkg::ValueWidth-1:0] value_in;

   logic [glfsr_pkg::ValueWidth-1:0] span;
   logic [glfsr_pkg::ValueWidth-1:0] rem_shift;
   logic [glfsr_pkg::ValueWidth:0]   diff;
   logic [glfsr_pkg::ValueWidth-1:0] rem_step;

   assign next_state = glfsr_pkg::lfsr_next(shift_ff, dir_ff);

   // Modulus is high - low + 1; reversed bounds use a divisor above any state.
   assign span = {1'b0, req_range_high} - {1'b0, req_range_low} + 17'd1;

   // One restoring step: bring down the next dividend bit, subtract if it fits.
   assign rem_shift = {rem_ff[glfsr_pkg::StateWidth-1:0], dvd_ff[glfsr_pkg::StateWidth-1]};
   assign diff      = {1'b0, rem_shift} - {1'b0, dsr_ff};
   assign rem_step  = diff[glfsr_pkg::ValueWidth] ? rem_shift
                                                  : diff[glfsr_pkg::ValueWidth-1:0];

   assign dp_status.last_iter =
      (count_ff == glfsr_pkg::CountWidth'(glfsr_pkg::IterCount - 1));

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      dsr_in   = dsr_ff;
      low_in   = low_ff;
      count_in = count_ff;
      value_in = value_ff;
      if (dp_cmd.load_seed) begin
         shift_in = req_seed;
      end
      if (dp_cmd.step_raw) begin
         shift_in = next_state;
         value_in = {1'b0, next_state};
      end
      if (dp_cmd.step_range) begin
         shift_in = next_state;
         rem_in   = '0;
         dvd_in   = next_state;
         dsr_in   = (req_range_high < req_range_low) ? '1 : span;
         low_in   = req_range_low;
         count_in = '0;
      end
      if (dp_cmd.iterate) begin
         rem_in   = rem_step;
         dvd_in   = {dvd_ff[glfsr_pkg::StateWidth-2:0], 1'b0};
         count_in = count_ff + 1'b1;
      end
      if (dp_cmd.finish) begin
         value_in = rem_step + {1'b0, low_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         dir_ff   <= 1'b0;
      end else begin
         shift_ff <= shift_in;
         if (csr_write) begin
            dir_ff <= csr_shift_direction;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      dsr_ff   <= dsr_in;
      low_ff   <= low_in;
      count_ff <= count_in;
      value_ff <= value_in;
   end

   assign rsp_value = value_ff;

endmodule
